// ----- src/dta_pkg.sv -----
// Shared types and constants of the date and time adder.
`default_nettype none

package dta_pkg;

  // Largest increment that is added; larger ones are clamped to it.
  localparam int unsigned DELTA_MAX = 4095;

  // Largest year that is reported; larger years saturate with a flag.
  localparam int unsigned YEAR_MAX = 9999;

  // Working widths: time and day sums stay below 2**13, and the year
  // stays below 2**15 with every carry included.
  localparam int unsigned WORK_W = 13;
  localparam int unsigned YEAR_W = 15;
  localparam int unsigned Q_W    = 9;

  // Microprogram size and step counter width.
  localparam int unsigned UCODE_DEPTH = 12;
  localparam int unsigned UPC_W       = $clog2(UCODE_DEPTH);

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_QUOT,
    UOP_CARRY,
    UOP_LEAP,
    UOP_YEAR,
    UOP_MONTH,
    UOP_DONE
  } dta_op_t;

  typedef enum logic [1:0] {
    FSEL_SEC,
    FSEL_MIN,
    FSEL_HOUR,
    FSEL_MON
  } dta_fsel_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_SPAN,
    COND_LEN
  } dta_cond_t;

  typedef struct packed {
    dta_op_t          op;
    dta_fsel_t        fsel;
    dta_cond_t        cond;
    logic [UPC_W-1:0] jmp;
  } dta_uword_t;

  typedef struct packed {
    logic day_gt_span;
    logic day_gt_len;
  } dta_stat_t;

  typedef struct packed {
    logic        [13:0] base_year;
    logic        [3:0]  base_month;
    logic        [4:0]  base_day;
    logic        [4:0]  base_hour;
    logic        [5:0]  base_minute;
    logic        [5:0]  base_second;
    logic signed [12:0] add_years;
    logic signed [12:0] add_months;
    logic signed [12:0] add_days;
    logic signed [12:0] add_hours;
    logic signed [12:0] add_minutes;
    logic signed [12:0] add_seconds;
  } dta_in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        year_overflow;
  } dta_result_t;

endpackage

`default_nettype wire

// ----- src/date_time_adder_unit.sv -----
// Top level of the date and time adder: handshake, sequencer and datapath.
//
// Each item carries a Gregorian date and time and six increments; a
// negative or zero increment leaves its field alone, and increments above
// DELTA_MAX are clamped. The result item holds the normalized date and
// time, with the year saturated at 9999 and out_year_overflow set when it
// would have gone past that. One item is worked on at a time: after it is
// accepted, a microprogram runs on a shared divide-by-constant unit and a
// day-walk unit. The day walk takes a whole year in two steps and then
// one month per step, so its length grows with the number of whole years
// and further months that the day count steps across. The last step
// also waits for as long as a previous result is still held in the
// output register. The result sits in that output register, so the next
// item is taken as soon as the microprogram finishes, even while the
// previous result still waits for out_ready.
`default_nettype none

module date_time_adder_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire         [13:0] in_base_year,
  input  wire         [3:0]  in_base_month,
  input  wire         [4:0]  in_base_day,
  input  wire         [4:0]  in_base_hour,
  input  wire         [5:0]  in_base_minute,
  input  wire         [5:0]  in_base_second,
  input  wire signed  [12:0] in_add_years,
  input  wire signed  [12:0] in_add_months,
  input  wire signed  [12:0] in_add_days,
  input  wire signed  [12:0] in_add_hours,
  input  wire signed  [12:0] in_add_minutes,
  input  wire signed  [12:0] in_add_seconds,
  output logic               out_valid,
  input  wire                out_ready,
  output logic        [13:0] out_year,
  output logic        [3:0]  out_month,
  output logic        [4:0]  out_day,
  output logic        [4:0]  out_hour,
  output logic        [5:0]  out_minute,
  output logic        [5:0]  out_second,
  output logic               out_year_overflow
);

  dta_pkg::dta_in_t     in_item;
  dta_pkg::dta_uword_t  uword;
  dta_pkg::dta_stat_t   stat;
  dta_pkg::dta_result_t result;
  dta_pkg::dta_result_t res_r;
  logic                 busy;
  logic                 done;
  logic                 start;
  logic                 out_free;
  logic                 out_valid_r;

  // A new item enters only while the microprogram is stopped.
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  // The output register can take a result when it is empty or being read.
  assign out_free = !out_valid_r || out_ready;

  assign in_item.base_year   = in_base_year;
  assign in_item.base_month  = in_base_month;
  assign in_item.base_day    = in_base_day;
  assign in_item.base_hour   = in_base_hour;
  assign in_item.base_minute = in_base_minute;
  assign in_item.base_second = in_base_second;
  assign in_item.add_years   = in_add_years;
  assign in_item.add_months  = in_add_months;
  assign in_item.add_days    = in_add_days;
  assign in_item.add_hours   = in_add_hours;
  assign in_item.add_minutes = in_add_minutes;
  assign in_item.add_seconds = in_add_seconds;

  dta_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .uword    (uword),
    .busy     (busy),
    .done     (done)
  );

  dta_datapath u_dp (
    .clk     (clk),
    .load    (start),
    .in_item (in_item),
    .uword   (uword),
    .stat    (stat),
    .result  (result)
  );

  // The final step of the microprogram waits here until the output
  // register is free, then hands the result over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_year          = res_r.year;
  assign out_month         = res_r.month;
  assign out_day           = res_r.day;
  assign out_hour          = res_r.hour;
  assign out_minute        = res_r.minute;
  assign out_second        = res_r.second;
  assign out_year_overflow = res_r.year_overflow;

`ifndef SYNTHESIS
  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an item was accepted");

  // A result only appears when the microprogram was running.
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("result appeared without a running microprogram");

  // A held result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  // Every result has month, hour, minute and second in range and a day of at least 1.
  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 &&
                   out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60))
    else $error("result not normalized");

  // The overflow flag is raised only together with a saturated year.
  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_year_overflow) |-> (out_year == 14'(dta_pkg::YEAR_MAX)))
    else $error("overflow flag without a saturated year");
`endif

endmodule

`default_nettype wire

// ----- src/dta_sequencer.sv -----
// Microprogram store and step counter of the date and time adder.
`default_nettype none

module dta_sequencer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire                  out_free,
  input  wire dta_pkg::dta_stat_t stat,
  output dta_pkg::dta_uword_t  uword,
  output logic                 busy,
  output logic                 done
);

  localparam logic [dta_pkg::UPC_W-1:0] STEP_START = dta_pkg::UPC_W'(0);
  localparam logic [dta_pkg::UPC_W-1:0] STEP_LEAP  = dta_pkg::UPC_W'(8);
  localparam logic [dta_pkg::UPC_W-1:0] STEP_MONTH = dta_pkg::UPC_W'(10);

  localparam dta_pkg::dta_uword_t NOP_WORD =
    '{dta_pkg::UOP_NOP, dta_pkg::FSEL_SEC, dta_pkg::COND_NONE, STEP_START};

  // Divide and carry seconds, minutes, hours and months, then walk the days
  // a whole year at a time and finally a month at a time.
  localparam dta_pkg::dta_uword_t UCODE [dta_pkg::UCODE_DEPTH] = '{
    '{dta_pkg::UOP_QUOT,  dta_pkg::FSEL_SEC,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_CARRY, dta_pkg::FSEL_SEC,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_QUOT,  dta_pkg::FSEL_MIN,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_CARRY, dta_pkg::FSEL_MIN,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_QUOT,  dta_pkg::FSEL_HOUR, dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_CARRY, dta_pkg::FSEL_HOUR, dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_QUOT,  dta_pkg::FSEL_MON,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_CARRY, dta_pkg::FSEL_MON,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_LEAP,  dta_pkg::FSEL_SEC,  dta_pkg::COND_NONE, STEP_START},
    '{dta_pkg::UOP_YEAR,  dta_pkg::FSEL_SEC,  dta_pkg::COND_SPAN, STEP_LEAP},
    '{dta_pkg::UOP_MONTH, dta_pkg::FSEL_SEC,  dta_pkg::COND_LEN,  STEP_MONTH},
    '{dta_pkg::UOP_DONE,  dta_pkg::FSEL_SEC,  dta_pkg::COND_NONE, STEP_START}
  };

  logic [dta_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic                      run_r, run_nxt;
  dta_pkg::dta_uword_t       cw;
  logic                      taken;

  always_comb begin
    cw    = UCODE[upc_r];
    taken = 1'b0;
    unique case (cw.cond)
      dta_pkg::COND_NONE: taken = 1'b0;
      dta_pkg::COND_SPAN: taken = stat.day_gt_span;
      dta_pkg::COND_LEN:  taken = stat.day_gt_len;
      default:            taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt = upc_r;
    run_nxt = run_r;
    done    = 1'b0;
    if (start) begin
      upc_nxt = STEP_START;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cw.op == dta_pkg::UOP_DONE) begin
        if (out_free) begin
          run_nxt = 1'b0;
          done    = 1'b1;
        end
      end else if (taken) begin
        upc_nxt = cw.jmp;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_START;
      run_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      run_r <= run_nxt;
    end
  end

  assign uword = run_r ? cw : NOP_WORD;
  assign busy  = run_r;

endmodule

`default_nettype wire

// ----- src/dta_datapath.sv -----
// Working registers and arithmetic of the date and time adder.
`default_nettype none

module dta_datapath (
  input  wire                  clk,
  input  wire                  load,
  input  wire dta_pkg::dta_in_t    in_item,
  input  wire dta_pkg::dta_uword_t uword,
  output dta_pkg::dta_stat_t   stat,
  output dta_pkg::dta_result_t result
);

  localparam int unsigned W  = dta_pkg::WORK_W;
  localparam int unsigned YW = dta_pkg::YEAR_W;
  localparam int unsigned QW = dta_pkg::Q_W;
  localparam int unsigned PW = W + 14;

  // Exact reciprocals for every value below 2**13.
  localparam logic [13:0] RECIP_60 = 14'd8739;
  localparam logic [13:0] RECIP_24 = 14'd10923;
  localparam logic [13:0] RECIP_12 = 14'd10923;
  localparam logic [4:0]  SHIFT_60 = 5'd19;
  localparam logic [4:0]  SHIFT_24 = 5'd18;
  localparam logic [4:0]  SHIFT_12 = 5'd17;

  // A year is a multiple of 25 when its product with the inverse of 25
  // modulo 2**15 falls at or below this limit.
  localparam logic [YW-1:0] INV_25 = YW'(23593);
  localparam logic [YW-1:0] LIM_25 = YW'(1310);

  function automatic logic [11:0] clamp_inc(input logic signed [12:0] v);
    if (v[12]) begin
      return 12'd0;
    end else if ({5'd0, v[11:0]} > 17'(dta_pkg::DELTA_MAX)) begin
      return 12'(dta_pkg::DELTA_MAX);
    end else begin
      return v[11:0];
    end
  endfunction

  function automatic logic is_leap(input logic [YW-1:0] y);
    logic [YW-1:0] p;
    logic          div25;
    p     = YW'(y * INV_25);
    div25 = (p <= LIM_25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    unique case (m)
      4'd2:                      return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
      default:                   return 5'd31;
    endcase
  endfunction

  logic [YW-1:0] year_r;
  logic [W-1:0]  mon_r, day_r, hour_r, min_r, sec_r;
  logic [QW-1:0] q_r;
  logic          leap_r, leap_nx_r;

  logic [W-1:0]  src;
  logic [13:0]   recip;
  logic [4:0]    shamt;
  logic [5:0]    divisor;
  logic [PW-1:0] prod;
  logic [QW-1:0] q_nxt;
  logic [W-1:0]  rem;
  logic [8:0]    span;
  logic [4:0]    mlen;
  logic [3:0]    base_mon;
  logic [4:0]    base_day;

  always_comb begin
    src     = sec_r;
    recip   = RECIP_60;
    shamt   = SHIFT_60;
    divisor = 6'd60;
    unique case (uword.fsel)
      dta_pkg::FSEL_SEC: begin
        src = sec_r;
      end
      dta_pkg::FSEL_MIN: begin
        src = min_r;
      end
      dta_pkg::FSEL_HOUR: begin
        src     = hour_r;
        recip   = RECIP_24;
        shamt   = SHIFT_24;
        divisor = 6'd24;
      end
      dta_pkg::FSEL_MON: begin
        src     = mon_r;
        recip   = RECIP_12;
        shamt   = SHIFT_12;
        divisor = 6'd12;
      end
      default: begin
        src = sec_r;
      end
    endcase
    prod  = PW'(src) * PW'(recip);
    q_nxt = QW'(prod >> shamt);
    rem   = src - (W'(q_r) * W'(divisor));
  end

  // Days from this month to the same month a year on: February of this
  // year counts when the walk starts in January or February.
  always_comb begin
    span = 9'd365 + {8'd0, (mon_r <= W'(2)) ? leap_r : leap_nx_r};
    mlen = month_len(mon_r[3:0], leap_r);
    stat.day_gt_span = day_r > W'(span);
    stat.day_gt_len  = day_r > W'(mlen);
  end

  assign base_mon = (in_item.base_month == 4'd0) ? 4'd1 : in_item.base_month;
  assign base_day = (in_item.base_day == 5'd0) ? 5'd1 : in_item.base_day;

  always_ff @(posedge clk) begin
    if (load) begin
      year_r <= YW'(in_item.base_year) + YW'(clamp_inc(in_item.add_years));
      mon_r  <= W'(base_mon) + W'(clamp_inc(in_item.add_months)) - W'(1);
      day_r  <= W'(base_day) + W'(clamp_inc(in_item.add_days));
      hour_r <= W'(in_item.base_hour) + W'(clamp_inc(in_item.add_hours));
      min_r  <= W'(in_item.base_minute) + W'(clamp_inc(in_item.add_minutes));
      sec_r  <= W'(in_item.base_second) + W'(clamp_inc(in_item.add_seconds));
    end else begin
      unique case (uword.op)
        dta_pkg::UOP_QUOT: begin
          q_r <= q_nxt;
        end
        dta_pkg::UOP_CARRY: begin
          unique case (uword.fsel)
            dta_pkg::FSEL_SEC: begin
              sec_r <= rem;
              min_r <= min_r + W'(q_r);
            end
            dta_pkg::FSEL_MIN: begin
              min_r  <= rem;
              hour_r <= hour_r + W'(q_r);
            end
            dta_pkg::FSEL_HOUR: begin
              hour_r <= rem;
              day_r  <= day_r + W'(q_r);
            end
            dta_pkg::FSEL_MON: begin
              // The month register holds month minus one until here.
              mon_r  <= rem + W'(1);
              year_r <= year_r + YW'(q_r);
            end
            default: begin
            end
          endcase
        end
        dta_pkg::UOP_LEAP: begin
          leap_r    <= is_leap(year_r);
          leap_nx_r <= is_leap(year_r + YW'(1));
        end
        dta_pkg::UOP_YEAR: begin
          if (stat.day_gt_span) begin
            day_r  <= day_r - W'(span);
            year_r <= year_r + YW'(1);
          end
        end
        dta_pkg::UOP_MONTH: begin
          if (stat.day_gt_len) begin
            day_r <= day_r - W'(mlen);
            if (mon_r == W'(12)) begin
              // The next-year flag is not read again after the year walk.
              mon_r  <= W'(1);
              year_r <= year_r + YW'(1);
              leap_r <= leap_nx_r;
            end else begin
              mon_r <= mon_r + W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (year_r > YW'(dta_pkg::YEAR_MAX)) begin
      result.year          = 14'(dta_pkg::YEAR_MAX);
      result.year_overflow = 1'b1;
    end else begin
      result.year          = year_r[13:0];
      result.year_overflow = 1'b0;
    end
    result.month  = mon_r[3:0];
    result.day    = day_r[4:0];
    result.hour   = hour_r[4:0];
    result.minute = min_r[5:0];
    result.second = sec_r[5:0];
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_date_time_adder_unit.sv -----
// Self-checking testbench for date_time_adder_unit: directed and random date additions.
module tb_date_time_adder_unit;

  // The run gives up after this many clock cycles. The slowest correct run is
  // about 625 items, each with a sender gap, a day walk and a receiver stall,
  // plus the long receiver hold-off. The limit is several times that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 600;
  // This wait is longer than the slowest item, so it covers any stray result.
  localparam int unsigned DRAIN_CYCLES = 80;
  // The receiver stops taking results once, after this many results, for this
  // many cycles. Meanwhile the sender keeps offering items, so the block fills up.
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic signed [12:0] KEEP = -13'sd1;

  // The board predicts the normalized date for every accepted item. It holds
  // the predictions in order and compares each returned result with the
  // oldest one.
  class normalized_date_board;
    dta_pkg::dta_result_t pending_dates[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // A negative or zero increment adds nothing. A positive one is capped.
    function int unsigned step_of(logic signed [12:0] d);
      if (d[12]) return 0;
      if (d[11:0] > dta_pkg::DELTA_MAX) return dta_pkg::DELTA_MAX;
      return d[11:0];
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
        2:             return leap_year(y) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    function dta_pkg::dta_result_t add_and_normalize(dta_pkg::dta_in_t it);
      int unsigned yr, mo, dy, hr, mi, se, len;
      dta_pkg::dta_result_t r;
      yr = it.base_year;
      mo = (it.base_month == 0) ? 1 : it.base_month;
      dy = (it.base_day == 0) ? 1 : it.base_day;
      hr = it.base_hour;
      mi = it.base_minute;
      se = it.base_second;
      yr += step_of(it.add_years);
      mo += step_of(it.add_months);
      dy += step_of(it.add_days);
      hr += step_of(it.add_hours);
      mi += step_of(it.add_minutes);
      se += step_of(it.add_seconds);
      mi += se / 60;  se = se % 60;
      hr += mi / 60;  mi = mi % 60;
      dy += hr / 24;  hr = hr % 24;
      yr += (mo - 1) / 12;
      mo = (mo - 1) % 12 + 1;
      // Walk the day count forward one month at a time, following the
      // month lengths of the year it lands in.
      len = month_days(mo, yr);
      while (dy > len) begin
        dy -= len;
        mo++;
        if (mo > 12) begin
          mo = 1;
          yr++;
        end
        len = month_days(mo, yr);
      end
      r.year_overflow = 1'b0;
      if (yr > dta_pkg::YEAR_MAX) begin
        yr = dta_pkg::YEAR_MAX;
        r.year_overflow = 1'b1;
      end
      r.year   = 14'(yr);
      r.month  = 4'(mo);
      r.day    = 5'(dy);
      r.hour   = 5'(hr);
      r.minute = 6'(mi);
      r.second = 6'(se);
      return r;
    endfunction

    function void note_item(dta_pkg::dta_in_t it);
      pending_dates.push_back(add_and_normalize(it));
    endfunction

    function void check_field(string what, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, seen);
      end
    endfunction

    function void check_result(dta_pkg::dta_result_t got);
      dta_pkg::dta_result_t want;
      checked++;
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding: expected none, actual %0d-%0d-%0d",
                 $time, got.year, got.month, got.day);
        return;
      end
      want = pending_dates.pop_front();
      check_field("year", want.year, got.year);
      check_field("month", want.month, got.month);
      check_field("day", want.day, got.day);
      check_field("hour", want.hour, got.hour);
      check_field("minute", want.minute, got.minute);
      check_field("second", want.second, got.second);
      check_field("year_overflow", want.year_overflow, got.year_overflow);
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input of the block starts at a known value.
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [13:0] in_base_year = '0;
  logic        [3:0]  in_base_month = '0;
  logic        [4:0]  in_base_day = '0;
  logic        [4:0]  in_base_hour = '0;
  logic        [5:0]  in_base_minute = '0;
  logic        [5:0]  in_base_second = '0;
  logic signed [12:0] in_add_years = '0;
  logic signed [12:0] in_add_months = '0;
  logic signed [12:0] in_add_days = '0;
  logic signed [12:0] in_add_hours = '0;
  logic signed [12:0] in_add_minutes = '0;
  logic signed [12:0] in_add_seconds = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [13:0] out_year;
  logic        [3:0]  out_month;
  logic        [4:0]  out_day;
  logic        [4:0]  out_hour;
  logic        [5:0]  out_minute;
  logic        [5:0]  out_second;
  logic               out_year_overflow;

  normalized_date_board sb = new();

  date_time_adder_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_year      (in_base_year),
    .in_base_month     (in_base_month),
    .in_base_day       (in_base_day),
    .in_base_hour      (in_base_hour),
    .in_base_minute    (in_base_minute),
    .in_base_second    (in_base_second),
    .in_add_years      (in_add_years),
    .in_add_months     (in_add_months),
    .in_add_days       (in_add_days),
    .in_add_hours      (in_add_hours),
    .in_add_minutes    (in_add_minutes),
    .in_add_seconds    (in_add_seconds),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_year          (out_year),
    .out_month         (out_month),
    .out_day           (out_day),
    .out_hour          (out_hour),
    .out_minute        (out_minute),
    .out_second        (out_second),
    .out_year_overflow (out_year_overflow)
  );

  // The clock has a 12-unit period, high for half of it and low for the other half.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Builds an item from its twelve fields. The directed part is easier to
  // read this way.
  function automatic dta_pkg::dta_in_t make_item(
      int unsigned y, int unsigned mo, int unsigned d,
      int unsigned h, int unsigned mi, int unsigned s,
      logic signed [12:0] ay, logic signed [12:0] amo, logic signed [12:0] ad,
      logic signed [12:0] ah, logic signed [12:0] ami, logic signed [12:0] as_);
    dta_pkg::dta_in_t it;
    it.base_year   = 14'(y);
    it.base_month  = 4'(mo);
    it.base_day    = 5'(d);
    it.base_hour   = 5'(h);
    it.base_minute = 6'(mi);
    it.base_second = 6'(s);
    it.add_years   = ay;
    it.add_months  = amo;
    it.add_days    = ad;
    it.add_hours   = ah;
    it.add_minutes = ami;
    it.add_seconds = as_;
    return it;
  endfunction

  // Increments mix "keep", zero, small carries, the cap, and raw 13-bit
  // patterns. The raw patterns hold every negative value and toggle every bit.
  function automatic logic signed [12:0] random_increment();
    case ($urandom_range(0, 7))
      0:       return KEEP;
      1:       return 13'sd0;
      2, 3:    return 13'($urandom_range(1, 70));
      4:       return 13'($urandom_range(0, 4095));
      5:       return 13'sd4095;
      6:       return 13'($urandom);
      default: return 13'($urandom_range(1, 400));
    endcase
  endfunction

  // Most items are well-formed dates. Some sit near the year limit, so that
  // saturation is reached often. About a quarter use any value the field
  // widths allow: month or day zero, months above 12, hours up to 31,
  // minutes and seconds up to 63, and years above 9999.
  function automatic dta_pkg::dta_in_t random_item();
    dta_pkg::dta_in_t it;
    if ($urandom_range(0, 3) != 0) begin
      it.base_year   = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(9900, 9999))
                                                   : 14'($urandom_range(0, 9999));
      it.base_month  = 4'($urandom_range(1, 12));
      it.base_day    = 5'($urandom_range(1, 31));
      it.base_hour   = 5'($urandom_range(0, 23));
      it.base_minute = 6'($urandom_range(0, 59));
      it.base_second = 6'($urandom_range(0, 59));
    end else begin
      it.base_year   = 14'($urandom);
      it.base_month  = 4'($urandom);
      it.base_day    = 5'($urandom);
      it.base_hour   = 5'($urandom);
      it.base_minute = 6'($urandom);
      it.base_second = 6'($urandom);
    end
    it.add_years   = random_increment();
    it.add_months  = random_increment();
    it.add_days    = random_increment();
    it.add_hours   = random_increment();
    it.add_minutes = random_increment();
    it.add_seconds = random_increment();
    return it;
  endfunction

  // The sender idles for a random gap before each item. In two of every five
  // blocks of 40 items it never idles, so that items arrive back to back.
  function automatic int unsigned sender_gap(int unsigned idx);
    int unsigned phase;
    phase = (idx / 40) % 5;
    if (phase == 3 || phase == 4) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Payload and valid change only at the falling edge. The item counts as
  // taken at the first rising edge where in_ready is high. valid is lowered
  // only when a gap follows, so it never drops and rises again within one
  // time step.
  task automatic send_item(input dta_pkg::dta_in_t it, input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_base_year   = it.base_year;
    in_base_month  = it.base_month;
    in_base_day    = it.base_day;
    in_base_hour   = it.base_hour;
    in_base_minute = it.base_minute;
    in_base_second = it.base_second;
    in_add_years   = it.add_years;
    in_add_months  = it.add_months;
    in_add_days    = it.add_days;
    in_add_hours   = it.add_hours;
    in_add_minutes = it.add_minutes;
    in_add_seconds = it.add_seconds;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // Stimulus and the end of the run.
  initial begin
    dta_pkg::dta_in_t directed[$];
    int unsigned idx;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A zero date with every increment left out: month and day zero read as 1.
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, KEEP, KEEP, KEEP, KEEP, KEEP, KEEP));
    // The last second of year 9999 plus one second saturates the year and
    // raises the flag. The remaining fields still roll over to 1/1 00:00:00.
    directed.push_back(make_item(9999, 12, 31, 23, 59, 59, KEEP, KEEP, KEEP, KEEP, KEEP, 1));
    // Leap years: divisible by 4, century years that are not leap, and
    // multiples of 400. Year 0 is one of the multiples of 400.
    directed.push_back(make_item(2024, 2, 28, 12, 0, 0, KEEP, KEEP, 1, KEEP, KEEP, KEEP));
    directed.push_back(make_item(1900, 2, 28, 12, 0, 0, KEEP, KEEP, 1, KEEP, KEEP, KEEP));
    directed.push_back(make_item(2000, 2, 28, 12, 0, 0, KEEP, KEEP, 1, KEEP, KEEP, KEEP));
    directed.push_back(make_item(0, 2, 28, 0, 0, 0, KEEP, KEEP, 1, KEEP, KEEP, KEEP));
    // Seconds and minutes carry at exactly 60, and hours at exactly 24.
    directed.push_back(make_item(2023, 6, 15, 10, 20, 0, KEEP, KEEP, KEEP, KEEP, KEEP, 60));
    directed.push_back(make_item(2023, 6, 15, 10, 59, 30, KEEP, KEEP, KEEP, KEEP, 1, KEEP));
    directed.push_back(make_item(2023, 6, 15, 23, 0, 0, KEEP, KEEP, KEEP, 1, KEEP, KEEP));
    // A December month carry moves into the next year.
    directed.push_back(make_item(2023, 12, 10, 0, 0, 0, KEEP, 1, KEEP, KEEP, KEEP, KEEP));
    // January 31 plus a month overflows February and carries into March.
    directed.push_back(make_item(2023, 1, 31, 0, 0, 0, KEEP, 1, KEEP, KEEP, KEEP, KEEP));
    // Zero increments leave every field unchanged, like "keep" does.
    directed.push_back(make_item(1999, 7, 4, 8, 30, 15, 0, 0, 0, 0, 0, 0));
    // Other negative values also add nothing, the most negative one included.
    directed.push_back(make_item(1999, 7, 4, 8, 30, 15,
                                 -13'sd2, -13'sd4096, -13'sd100, -13'sd4096, -13'sd2, -13'sd3));
    // Every increment at its largest allowed value, then the day increment alone.
    directed.push_back(make_item(0, 1, 1, 0, 0, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    directed.push_back(make_item(2023, 12, 31, 23, 59, 59, KEEP, KEEP, 4095, KEEP, KEEP, KEEP));
    // Base fields above their ranges go through the normal carries.
    directed.push_back(make_item(2001, 15, 31, 31, 63, 63, KEEP, KEEP, KEEP, KEEP, KEEP, KEEP));
    directed.push_back(make_item(2023, 4, 31, 0, 0, 0, KEEP, KEEP, KEEP, KEEP, KEEP, KEEP));
    directed.push_back(make_item(2023, 2, 31, 5, 5, 5, KEEP, KEEP, KEEP, KEEP, KEEP, KEEP));
    // Base years above 9999 saturate even when nothing is added; so does a year pushed past it.
    directed.push_back(make_item(16383, 3, 3, 3, 3, 3, KEEP, KEEP, KEEP, KEEP, KEEP, KEEP));
    directed.push_back(make_item(9999, 1, 1, 0, 0, 0, 4095, KEEP, KEEP, KEEP, KEEP, KEEP));
    // All base fields at full width with all increments at their largest.
    directed.push_back(make_item(16383, 15, 31, 31, 63, 63, 4095, 4095, 4095, 4095, 4095, 4095));

    idx = 0;
    foreach (directed[i]) begin
      send_item(directed[i], sender_gap(idx));
      idx++;
    end
    repeat (RANDOM_ITEMS) begin
      send_item(random_item(), sender_gap(idx));
      idx++;
    end
    @(negedge clk);
    in_valid = 1'b0;

    // Wait until every prediction has been matched. Then give a stray result
    // time to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side. out_ready changes at the falling edge, and a result is taken
  // at a rising edge where out_valid and out_ready are both high. The stall
  // before each result is random. Some blocks of results have no stalls at
  // all. One long hold-off backs the block up onto its input.
  initial begin
    int unsigned stall;
    int unsigned phase;
    bit held;
    dta_pkg::dta_result_t got;
    held = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      phase = (sb.checked / 40) % 5;
      if (!held && sb.checked == HOLD_AT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (phase == 2 || phase == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.year          = out_year;
      got.month         = out_month;
      got.day           = out_day;
      got.hour          = out_hour;
      got.minute        = out_minute;
      got.second        = out_second;
      got.year_overflow = out_year_overflow;
      sb.check_result(got);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/dta_pkg.sv
src/dta_sequencer.sv
src/dta_datapath.sv
src/date_time_adder_unit.sv
tb/sv/tb_date_time_adder_unit.sv
